// ----- hw/rtl/kalman_two_state_step_assert.svh -----
// Assertion macros shared by the kalman_two_state_step RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef KALMAN_TWO_STATE_STEP_ASSERT_SVH
`define KALMAN_TWO_STATE_STEP_ASSERT_SVH

// Same-cycle implication.
`define KTS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define KTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/kts_pkg.sv -----
// Package for kalman_two_state_step: widths, register map, shared types
// and saturating fixed-point helpers. No dependencies.
package kts_pkg;

   localparam int DATA_WIDTH     = 32;
   localparam int FRAC_BITS      = 16;
   localparam int PROD_WIDTH     = 2 * DATA_WIDTH;
   localparam int QUO_WIDTH      = DATA_WIDTH + FRAC_BITS;
   localparam int MUL_STEPS      = DATA_WIDTH;
   localparam int DIV_STEPS      = QUO_WIDTH;
   localparam int MUL_CNT_WIDTH  = $clog2(MUL_STEPS);
   localparam int DIV_CNT_WIDTH  = $clog2(DIV_STEPS);
   localparam int UWIDTH         = 31;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [UWIDTH-1:0]     RST_STEP_COUPLING     = UWIDTH'(32768);
   localparam logic [DATA_WIDTH-1:0] RST_CONTROL_GAIN      = DATA_WIDTH'(32768);
   localparam logic [UWIDTH-1:0]     RST_PROCESS_NOISE     = UWIDTH'(6554);
   localparam logic [UWIDTH-1:0]     RST_MEASUREMENT_NOISE = UWIDTH'(3277);
   localparam logic [DATA_WIDTH-1:0] RST_INITIAL_POSITION  = DATA_WIDTH'(0);
   localparam logic [DATA_WIDTH-1:0] RST_INITIAL_VELOCITY  = DATA_WIDTH'(327680);
   localparam logic [UWIDTH-1:0]     RST_INITIAL_POS_VAR   = UWIDTH'(655);
   localparam logic [UWIDTH-1:0]     RST_INITIAL_VEL_VAR   = UWIDTH'(65536);

   localparam logic [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   localparam logic CMD_STEP    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   typedef enum logic [2:0] {
      REG_STEP_COUPLING,
      REG_CONTROL_GAIN,
      REG_PROCESS_NOISE,
      REG_MEASUREMENT_NOISE,
      REG_INITIAL_POSITION,
      REG_INITIAL_VELOCITY,
      REG_INITIAL_POS_VARIANCE,
      REG_INITIAL_VEL_VARIANCE
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_XP,
      OP_VP,
      OP_FP00,
      OP_P01,
      OP_P00,
      OP_S,
      OP_K0,
      OP_K1,
      OP_X,
      OP_V,
      OP_C00,
      OP_C01,
      OP_C11
   } op_type;

   typedef struct packed {
      logic [UWIDTH-1:0]     step_coupling;
      logic [DATA_WIDTH-1:0] control_gain;
      logic [UWIDTH-1:0]     process_noise;
      logic [UWIDTH-1:0]     measurement_noise;
      logic [DATA_WIDTH-1:0] initial_position;
      logic [DATA_WIDTH-1:0] initial_velocity;
      logic [UWIDTH-1:0]     initial_pos_variance;
      logic [UWIDTH-1:0]     initial_vel_variance;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      logic [DATA_WIDTH-1:0] a;
      logic [DATA_WIDTH-1:0] b;
   } unit_req_type;

   typedef struct packed {
      logic                  sat;
      logic [DATA_WIDTH-1:0] value;
   } res_type;

   typedef struct packed {
      logic    done;
      res_type res;
   } unit_rsp_type;

   function automatic logic [DATA_WIDTH-1:0] magnitude(input logic [DATA_WIDTH-1:0] a);
      magnitude = a[DATA_WIDTH-1] ? DATA_WIDTH'(~a + 1'b1) : a;
   endfunction

   function automatic res_type fit_mag(input logic [QUO_WIDTH-1:0] m, input logic neg);
      logic [DATA_WIDTH-1:0] lim;
      res_type               r;
      lim     = neg ? WORD_MIN : WORD_MAX;
      r.sat   = m > QUO_WIDTH'(lim);
      if (r.sat) begin
         r.value = neg ? WORD_MIN : WORD_MAX;
      end else begin
         r.value = neg ? DATA_WIDTH'(~m[DATA_WIDTH-1:0] + 1'b1) : m[DATA_WIDTH-1:0];
      end
      fit_mag = r;
   endfunction

   function automatic res_type sat_add(input logic [DATA_WIDTH-1:0] a,
                                       input logic [DATA_WIDTH-1:0] b);
      logic [DATA_WIDTH:0] s;
      res_type             r;
      s     = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
      r.sat = s[DATA_WIDTH] != s[DATA_WIDTH-1];
      r.value = r.sat ? (s[DATA_WIDTH] ? WORD_MIN : WORD_MAX) : s[DATA_WIDTH-1:0];
      sat_add = r;
   endfunction

   function automatic res_type sat_sub(input logic [DATA_WIDTH-1:0] a,
                                       input logic [DATA_WIDTH-1:0] b);
      logic [DATA_WIDTH:0] s;
      res_type             r;
      s     = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
      r.sat = s[DATA_WIDTH] != s[DATA_WIDTH-1];
      r.value = r.sat ? (s[DATA_WIDTH] ? WORD_MIN : WORD_MAX) : s[DATA_WIDTH-1:0];
      sat_sub = r;
   endfunction

endpackage

// ----- hw/rtl/kts_channels.sv -----
// Request and response channel interfaces for kalman_two_state_step.
// Depends on kts_pkg.
interface kts_req_if;
   import kts_pkg::*;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic signed [DATA_WIDTH-1:0] control_input;
   logic signed [DATA_WIDTH-1:0] measurement;
   modport source (output valid, command, control_input, measurement, input ready);
   modport sink (input valid, command, control_input, measurement, output ready);
endinterface

interface kts_rsp_if;
   import kts_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] position_estimate;
   logic signed [DATA_WIDTH-1:0] velocity_estimate;
   logic signed [DATA_WIDTH-1:0] gain_position;
   logic signed [DATA_WIDTH-1:0] gain_velocity;
   logic signed [DATA_WIDTH-1:0] innovation;
   logic                         error_flag;
   modport source (output valid, position_estimate, velocity_estimate, gain_position,
                   gain_velocity, innovation, error_flag, input ready);
   modport sink (input valid, position_estimate, velocity_estimate, gain_position,
                 gain_velocity, innovation, error_flag, output ready);
endinterface

// ----- hw/rtl/kts_csr.sv -----
// APB-style configuration register file for kalman_two_state_step.
// Depends on kts_pkg.
module kts_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [kts_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [kts_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [kts_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready,
   output kts_pkg::cfg_type                    cfg
);
   import kts_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_coupling        <= RST_STEP_COUPLING;
         cfg_ff.control_gain         <= RST_CONTROL_GAIN;
         cfg_ff.process_noise        <= RST_PROCESS_NOISE;
         cfg_ff.measurement_noise    <= RST_MEASUREMENT_NOISE;
         cfg_ff.initial_position     <= RST_INITIAL_POSITION;
         cfg_ff.initial_velocity     <= RST_INITIAL_VELOCITY;
         cfg_ff.initial_pos_variance <= RST_INITIAL_POS_VAR;
         cfg_ff.initial_vel_variance <= RST_INITIAL_VEL_VAR;
      end else if (wr_en) begin
         case (index)
            REG_STEP_COUPLING:        cfg_ff.step_coupling <= csr_pwdata[UWIDTH-1:0];
            REG_CONTROL_GAIN:         cfg_ff.control_gain <= csr_pwdata[DATA_WIDTH-1:0];
            REG_PROCESS_NOISE:        cfg_ff.process_noise <= csr_pwdata[UWIDTH-1:0];
            REG_MEASUREMENT_NOISE:    cfg_ff.measurement_noise <= csr_pwdata[UWIDTH-1:0];
            REG_INITIAL_POSITION:     cfg_ff.initial_position <= csr_pwdata[DATA_WIDTH-1:0];
            REG_INITIAL_VELOCITY:     cfg_ff.initial_velocity <= csr_pwdata[DATA_WIDTH-1:0];
            REG_INITIAL_POS_VARIANCE: cfg_ff.initial_pos_variance <= csr_pwdata[UWIDTH-1:0];
            REG_INITIAL_VEL_VARIANCE: cfg_ff.initial_vel_variance <= csr_pwdata[UWIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_STEP_COUPLING:        csr_prdata = CSR_DATA_WIDTH'(cfg_ff.step_coupling);
         REG_CONTROL_GAIN:         csr_prdata = CSR_DATA_WIDTH'(cfg_ff.control_gain);
         REG_PROCESS_NOISE:        csr_prdata = CSR_DATA_WIDTH'(cfg_ff.process_noise);
         REG_MEASUREMENT_NOISE:    csr_prdata = CSR_DATA_WIDTH'(cfg_ff.measurement_noise);
         REG_INITIAL_POSITION:     csr_prdata = CSR_DATA_WIDTH'(cfg_ff.initial_position);
         REG_INITIAL_VELOCITY:     csr_prdata = CSR_DATA_WIDTH'(cfg_ff.initial_velocity);
         REG_INITIAL_POS_VARIANCE: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.initial_pos_variance);
         REG_INITIAL_VEL_VARIANCE: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.initial_vel_variance);
         default:                  csr_prdata = '0;
      endcase
   end

endmodule

// ----- hw/rtl/kts_serial_mul.sv -----
// Bit-serial saturating fixed-point multiplier, one multiplier bit per cycle.
// Depends on kts_pkg.
module kts_serial_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  kts_pkg::unit_req_type mul_req,
   output kts_pkg::unit_rsp_type mul_rsp
);
   import kts_pkg::*;

   logic                     busy_ff;
   logic                     done_ff;
   logic [MUL_CNT_WIDTH-1:0] cnt_ff;
   logic [DATA_WIDTH-1:0]    ma_ff;
   logic [DATA_WIDTH-1:0]    mb_ff;
   logic                     neg_ff;
   logic [PROD_WIDTH-1:0]    acc_ff;
   logic [DATA_WIDTH:0]      sum_in;

   assign sum_in = {1'b0, acc_ff[PROD_WIDTH-1:DATA_WIDTH]}
                 + {1'b0, (mb_ff[0] ? ma_ff : {DATA_WIDTH{1'b0}})};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == MUL_CNT_WIDTH'(MUL_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         ma_ff  <= magnitude(mul_req.a);
         mb_ff  <= magnitude(mul_req.b);
         neg_ff <= mul_req.a[DATA_WIDTH-1] ^ mul_req.b[DATA_WIDTH-1];
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= {sum_in, acc_ff[DATA_WIDTH-1:1]};
         mb_ff  <= mb_ff >> 1;
      end
   end

   assign mul_rsp = {done_ff, fit_mag(acc_ff[PROD_WIDTH-1:FRAC_BITS], neg_ff)};

endmodule

// ----- hw/rtl/kts_serial_div.sv -----
// Bit-serial restoring divider for saturating fixed-point quotients,
// one quotient bit per cycle. Depends on kts_pkg.
module kts_serial_div (
   input  logic                  clock,
   input  logic                  reset,
   input  kts_pkg::unit_req_type div_req,
   output kts_pkg::unit_rsp_type div_rsp
);
   import kts_pkg::*;

   logic                     busy_ff;
   logic                     done_ff;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff;
   logic [QUO_WIDTH-1:0]     num_ff;
   logic [DATA_WIDTH-1:0]    ud_ff;
   logic [DATA_WIDTH-1:0]    rem_ff;
   logic                     neg_ff;
   logic [DATA_WIDTH:0]      trial;
   logic [DATA_WIDTH:0]      diff;
   logic                     ge;

   assign trial = {rem_ff, num_ff[QUO_WIDTH-1]};
   assign diff  = trial - {1'b0, ud_ff};
   assign ge    = trial >= {1'b0, ud_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_WIDTH'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         num_ff <= {magnitude(div_req.a), {FRAC_BITS{1'b0}}};
         ud_ff  <= magnitude(div_req.b);
         rem_ff <= '0;
         neg_ff <= div_req.a[DATA_WIDTH-1] ^ div_req.b[DATA_WIDTH-1];
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
         num_ff <= {num_ff[QUO_WIDTH-2:0], ge};
      end
   end

   assign div_rsp = {done_ff, fit_mag(num_ff, neg_ff)};

endmodule

// ----- hw/rtl/kalman_two_state_step.sv -----
// Two-state position/velocity Kalman filter step, Q16.16, top level.
// Depends on kts_pkg, kts_channels, kts_csr, kts_serial_mul, kts_serial_div.
//
//   channel   direction  handshake          payload
//   req_chan  in         valid/ready        command, control_input, measurement
//   rsp_chan  out        valid/ready        estimates, gains, innovation, error_flag
//   csr_*     in/out     APB psel/penable   eight registers of up to 32 bits at 4*i
//
// A filter step from one request to the next runs ten products on the one-bit
// shift-add multiplier, two quotients on the restoring divider, one innovation
// variance step, an idle state and an output state. With zero innovation
// variance the quotients are skipped. A restart goes straight from the idle
// state to the output state.
// Reset is synchronous and loads the state from the register reset values.
// A request is taken only when the sequencer is idle; a finished response
// waits in the output register while the next request is accepted, and the
// output cycle stalls while an earlier response is still held.
module kalman_two_state_step (
   input  logic                               clock,
   input  logic                               reset,
   kts_req_if.sink                            req_chan,
   kts_rsp_if.source                          rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [kts_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [kts_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [kts_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);
   import kts_pkg::*;
`include "kalman_two_state_step_assert.svh"

   cfg_type      cfg;
   unit_req_type mul_req;
   unit_req_type div_req;
   unit_rsp_type mul_rsp;
   unit_rsp_type div_rsp;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [DATA_WIDTH-1:0] x_ff, v_ff, c00_ff, c01_ff, c11_ff;
   logic [DATA_WIDTH-1:0] xp_ff, vp_ff, fp00_ff, p01_ff, p00_ff, p11_ff;
   logic [DATA_WIDTH-1:0] s_ff, e_ff, k0_ff, k1_ff, u_ff, y_ff;
   logic                  err_ff;

   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rsp_pos_ff, rsp_vel_ff, rsp_k0_ff, rsp_k1_ff, rsp_e_ff;
   logic                  rsp_err_ff;

   logic                  req_fire;
   logic                  out_load;
   logic                  mul_start;
   logic                  div_start;
   logic                  s_zero;
   logic [DATA_WIDTH-1:0] f_word, q_word, r_word, base;
   res_type               wb_res, p00_res, p11_res, s_res, e_res;

   kts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   kts_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   kts_serial_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign f_word = {1'b0, cfg.step_coupling};
   assign q_word = {1'b0, cfg.process_noise};
   assign r_word = {1'b0, cfg.measurement_noise};

   assign req_fire = req_chan.valid && req_chan.ready;

   assign s_res  = sat_add(p00_ff, r_word);
   assign e_res  = sat_sub(y_ff, xp_ff);
   assign s_zero = s_res.value == '0;

   always_comb begin
      mul_req.start = mul_start;
      mul_req.a     = f_word;
      mul_req.b     = x_ff;
      base          = x_ff;
      case (op_ff)
         OP_XP:   begin mul_req.a = f_word; mul_req.b = v_ff;   base = x_ff;    end
         OP_VP:   begin mul_req.a = cfg.control_gain; mul_req.b = u_ff; base = v_ff; end
         OP_FP00: begin mul_req.a = f_word; mul_req.b = c01_ff; base = c00_ff;  end
         OP_P01:  begin mul_req.a = f_word; mul_req.b = c11_ff; base = c01_ff;  end
         OP_P00:  begin mul_req.a = f_word; mul_req.b = p01_ff; base = fp00_ff; end
         OP_X:    begin mul_req.a = k0_ff;  mul_req.b = e_ff;   base = xp_ff;   end
         OP_V:    begin mul_req.a = k1_ff;  mul_req.b = e_ff;   base = vp_ff;   end
         OP_C00:  begin mul_req.a = k0_ff;  mul_req.b = p00_ff; base = p00_ff;  end
         OP_C01:  begin mul_req.a = k0_ff;  mul_req.b = p01_ff; base = p01_ff;  end
         OP_C11:  begin mul_req.a = k1_ff;  mul_req.b = p01_ff; base = p11_ff;  end
         default: ;
      endcase
   end

   assign wb_res  = (op_ff == OP_C00 || op_ff == OP_C01 || op_ff == OP_C11)
                  ? sat_sub(base, mul_rsp.res.value) : sat_add(base, mul_rsp.res.value);
   assign p00_res = sat_add(wb_res.value, q_word);
   assign p11_res = sat_add(c11_ff, q_word);

   always_comb begin
      div_req.start = div_start;
      div_req.a     = (op_ff == OP_K1) ? p01_ff : p00_ff;
      div_req.b     = s_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_XP;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      req_chan.ready = 1'b0;
      mul_start      = 1'b0;
      div_start      = 1'b0;
      out_load       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = !reset;
            if (req_chan.valid && !reset) begin
               op_in    = OP_XP;
               state_in = (req_chan.command == CMD_RESTART) ? ST_OUT : ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (op_ff == OP_S) begin
               op_in = s_zero ? OP_X : OP_K0;
            end else if (op_ff == OP_K0 || op_ff == OP_K1) begin
               div_start = 1'b1;
               state_in  = ST_WAIT;
            end else begin
               mul_start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mul_rsp.done || div_rsp.done) begin
               if (op_ff == OP_C11) begin
                  state_in = ST_OUT;
               end else begin
                  op_in    = op_type'(op_ff + 1'b1);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff   <= RST_INITIAL_POSITION;
         v_ff   <= RST_INITIAL_VELOCITY;
         c00_ff <= {1'b0, RST_INITIAL_POS_VAR};
         c01_ff <= '0;
         c11_ff <= {1'b0, RST_INITIAL_VEL_VAR};
      end else begin
         if (req_fire && req_chan.command == CMD_RESTART) begin
            x_ff   <= cfg.initial_position;
            v_ff   <= cfg.initial_velocity;
            c00_ff <= {1'b0, cfg.initial_pos_variance};
            c01_ff <= '0;
            c11_ff <= {1'b0, cfg.initial_vel_variance};
         end
         if (state_ff == ST_WAIT && mul_rsp.done) begin
            case (op_ff)
               OP_X:    x_ff   <= wb_res.value;
               OP_V:    v_ff   <= wb_res.value;
               OP_C00:  c00_ff <= wb_res.value;
               OP_C01:  c01_ff <= wb_res.value;
               OP_C11:  c11_ff <= wb_res.value;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         u_ff   <= req_chan.control_input;
         y_ff   <= req_chan.measurement;
         err_ff <= 1'b0;
         k0_ff  <= '0;
         k1_ff  <= '0;
         e_ff   <= '0;
      end
      if (state_ff == ST_ISSUE && op_ff == OP_S) begin
         s_ff   <= s_res.value;
         e_ff   <= e_res.value;
         err_ff <= err_ff | s_res.sat | e_res.sat | s_zero;
      end
      if (state_ff == ST_WAIT && mul_rsp.done) begin
         case (op_ff)
            OP_XP:   xp_ff   <= wb_res.value;
            OP_VP:   vp_ff   <= wb_res.value;
            OP_FP00: fp00_ff <= wb_res.value;
            OP_P01:  p01_ff  <= wb_res.value;
            OP_P00: begin
               p00_ff <= p00_res.value;
               p11_ff <= p11_res.value;
            end
            default: ;
         endcase
         err_ff <= err_ff | mul_rsp.res.sat | wb_res.sat
                 | ((op_ff == OP_P00) & (p00_res.sat | p11_res.sat));
      end
      if (state_ff == ST_WAIT && div_rsp.done) begin
         if (op_ff == OP_K1) begin
            k1_ff <= div_rsp.res.value;
         end else begin
            k0_ff <= div_rsp.res.value;
         end
         err_ff <= err_ff | div_rsp.res.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pos_ff <= x_ff;
         rsp_vel_ff <= v_ff;
         rsp_k0_ff  <= k0_ff;
         rsp_k1_ff  <= k1_ff;
         rsp_e_ff   <= e_ff;
         rsp_err_ff <= err_ff;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.position_estimate = rsp_pos_ff;
   assign rsp_chan.velocity_estimate = rsp_vel_ff;
   assign rsp_chan.gain_position     = rsp_k0_ff;
   assign rsp_chan.gain_velocity     = rsp_k1_ff;
   assign rsp_chan.innovation        = rsp_e_ff;
   assign rsp_chan.error_flag        = rsp_err_ff;

   `KTS_ASSERT_IMPLY(unit_done_in_wait, mul_rsp.done || div_rsp.done, state_ff == ST_WAIT, "unit finished outside wait state")
   `KTS_ASSERT_NEXT(request_leaves_idle, req_fire, state_ff != ST_IDLE, "accepted request left sequencer idle")
   `KTS_ASSERT_NEXT(load_shows_response, out_load, rsp_valid_ff, "response load did not raise valid")

endmodule

// ----- dv/tb_kalman_two_state_step.sv -----
// Self-checking testbench for kalman_two_state_step: drives step and restart
// requests with random handshake gaps, programs the APB registers between phases,
// and checks every response against a fixed-point filter model or a given value.
// Depends on kts_pkg, kts_channels and the kalman_two_state_step RTL.
module tb_kalman_two_state_step;
   import kts_pkg::*;

   localparam longint WMAX = 64'sd2147483647;
   localparam longint WMIN = -64'sd2147483648;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int RANDOM_ITEMS = 1330;

   typedef struct packed {
      logic [31:0] pos;
      logic [31:0] vel;
      logic [31:0] k0;
      logic [31:0] k1;
      logic [31:0] innov;
      logic        err;
   } estimate_type;

   typedef struct {
      logic         cmd;
      logic [31:0]  u;
      logic [31:0]  y;
      bit           typed;
      estimate_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   kts_req_if req ();
   kts_rsp_if rsp ();

   kalman_two_state_step DUT (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   longint cfg_val [8];
   longint pos_q, vel_q, c00, c01, c11;
   bit     sat_seen;
   estimate_type expected_estimates [$];
   int     mismatches = 0;
   int     cycles = 0;
   bit     quiet = 0;

   function automatic longint fit_word(longint a);
      if (a > WMAX) begin sat_seen = 1; return WMAX; end
      if (a < WMIN) begin sat_seen = 1; return WMIN; end
      return a;
   endfunction

   function automatic longint unsigned mag(longint a);
      return a < 0 ? longint'(-a) : a;
   endfunction

   function automatic longint from_mag(longint unsigned m, bit neg);
      longint unsigned lim;
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      if (m > lim) begin
         sat_seen = 1;
         return neg ? WMIN : WMAX;
      end
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint qmul(longint a, longint b);
      return from_mag((mag(a) * mag(b)) >> FRAC_BITS, (a < 0) != (b < 0));
   endfunction

   function automatic longint qdiv(longint n, longint d);
      return from_mag((mag(n) << FRAC_BITS) / mag(d), (n < 0) != (d < 0));
   endfunction

   function automatic longint sgn32(logic [31:0] v);
      return longint'($signed(v));
   endfunction

   function automatic void load_initial();
      pos_q = cfg_val[REG_INITIAL_POSITION];
      vel_q = cfg_val[REG_INITIAL_VELOCITY];
      c00 = cfg_val[REG_INITIAL_POS_VARIANCE];
      c01 = 0;
      c11 = cfg_val[REG_INITIAL_VEL_VARIANCE];
   endfunction

   function automatic estimate_type filter_step(logic cmd, logic [31:0] u_in,
                                                logic [31:0] y_in);
      longint f, g, q, r, xp, vp, fp00, p01, p00, p11, s, k0, k1, e;
      estimate_type o;
      bit zero_s;
      sat_seen = 0;
      k0 = 0;
      k1 = 0;
      if (cmd == CMD_RESTART) begin
         load_initial();
         o = '0;
         o.pos = pos_q[31:0];
         o.vel = vel_q[31:0];
         return o;
      end
      f = cfg_val[REG_STEP_COUPLING];
      g = cfg_val[REG_CONTROL_GAIN];
      q = cfg_val[REG_PROCESS_NOISE];
      r = cfg_val[REG_MEASUREMENT_NOISE];
      xp = fit_word(pos_q + qmul(f, vel_q));
      vp = fit_word(vel_q + qmul(g, sgn32(u_in)));
      fp00 = fit_word(c00 + qmul(f, c01));
      p01 = fit_word(c01 + qmul(f, c11));
      p00 = fit_word(fit_word(fp00 + qmul(f, p01)) + q);
      p11 = fit_word(c11 + q);
      s = fit_word(p00 + r);
      e = fit_word(sgn32(y_in) - xp);
      zero_s = (s == 0);
      if (!zero_s) begin
         k0 = qdiv(p00, s);
         k1 = qdiv(p01, s);
      end
      pos_q = fit_word(xp + qmul(k0, e));
      vel_q = fit_word(vp + qmul(k1, e));
      c00 = fit_word(p00 - qmul(k0, p00));
      c01 = fit_word(p01 - qmul(k0, p01));
      c11 = fit_word(p11 - qmul(k1, p01));
      o.pos = pos_q[31:0];
      o.vel = vel_q[31:0];
      o.k0 = k0[31:0];
      o.k1 = k1[31:0];
      o.innov = e[31:0];
      o.err = zero_s | sat_seen;
      return o;
   endfunction

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = CSR_ADDR_WIDTH'(4 * int'(idx));
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      if (idx == REG_CONTROL_GAIN || idx == REG_INITIAL_POSITION
          || idx == REG_INITIAL_VELOCITY)
         cfg_val[idx] = sgn32(value);
      else
         cfg_val[idx] = longint'(value[30:0]);
   endtask

   task automatic drain();
      @(negedge clock);
      req.valid = 1'b0;
      while (expected_estimates.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic send(logic cmd, logic [31:0] u_in, logic [31:0] y_in,
                       bit typed = 0, estimate_type want = '0);
      estimate_type pred;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req.valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req.command = cmd;
      req.control_input = u_in;
      req.measurement = y_in;
      req.valid = 1'b1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pred = filter_step(cmd, u_in, y_in);
      expected_estimates.push_back(typed ? want : pred);
   endtask

   task automatic set_all(logic [31:0] v [8]);
      for (int i = 0; i < 8; i++) write_reg(reg_index_type'(i), v[i]);
   endtask

   function automatic logic [31:0] rand_small();
      return 32'($signed($urandom_range(0, 2 * 655360)) - 655360);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   int stall_left = 0;
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp.ready = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp.ready = 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp.ready = 1'b0;
      end else begin
         rsp.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      estimate_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = {rsp.position_estimate, rsp.velocity_estimate, rsp.gain_position,
                rsp.gain_velocity, rsp.innovation, rsp.error_flag};
         if (expected_estimates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            want = expected_estimates.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected pos %h vel %h k0 %h k1 %h e %h err %b, got pos %h vel %h k0 %h k1 %h e %h err %b",
                           want.pos, want.vel, want.k0, want.k1, want.innov, want.err,
                           got.pos, got.vel, got.k0, got.k1, got.innov, got.err);
            end
         end
      end
   end

   stim_row_type directed [] = '{
      '{CMD_RESTART, 32'h0, 32'h0, 1, '{32'h0, 32'd327680, 32'h0, 32'h0, 32'h0, 1'b0}},
      '{CMD_STEP, 32'h0, 32'h0, 0, '0},
      '{CMD_STEP, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, '0},
      '{CMD_STEP, 32'h80000000, 32'h80000000, 0, '0},
      '{CMD_STEP, 32'hFFFFFFFF, 32'h00010000, 0, '0},
      '{CMD_STEP, 32'h00010000, 32'hFFFF0000, 0, '0},
      '{CMD_RESTART, 32'hFFFFFFFF, 32'hFFFFFFFF, 1,
        '{32'h0, 32'd327680, 32'h0, 32'h0, 32'h0, 1'b0}},
      '{CMD_STEP, 32'h00020000, 32'h00050000, 0, '0},
      '{CMD_STEP, 32'h00008000, 32'h000A0000, 0, '0}
   };

   initial begin
      logic [31:0] extreme_hi [8] = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
         32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF};
      logic [31:0] zero_var [8] = '{32'h0, 32'h7FFFFFFF, 32'h0, 32'h0,
         32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0};
      logic [31:0] rand_cfg [8];
      estimate_type want;
      int sent;
      cfg_val[REG_STEP_COUPLING] = RST_STEP_COUPLING;
      cfg_val[REG_CONTROL_GAIN] = sgn32(RST_CONTROL_GAIN);
      cfg_val[REG_PROCESS_NOISE] = RST_PROCESS_NOISE;
      cfg_val[REG_MEASUREMENT_NOISE] = RST_MEASUREMENT_NOISE;
      cfg_val[REG_INITIAL_POSITION] = sgn32(RST_INITIAL_POSITION);
      cfg_val[REG_INITIAL_VELOCITY] = sgn32(RST_INITIAL_VELOCITY);
      cfg_val[REG_INITIAL_POS_VARIANCE] = RST_INITIAL_POS_VAR;
      cfg_val[REG_INITIAL_VEL_VARIANCE] = RST_INITIAL_VEL_VAR;
      load_initial();
      req.valid = 1'b0;
      req.command = CMD_STEP;
      req.control_input = '0;
      req.measurement = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         send(directed[i].cmd, directed[i].u, directed[i].y, directed[i].typed,
              directed[i].want);
      drain();

      set_all(extreme_hi);
      want = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, 32'h0, 1'b0};
      send(CMD_RESTART, 32'h0, 32'h0, 1, want);
      send(CMD_STEP, 32'h7FFFFFFF, 32'h80000000);
      send(CMD_STEP, 32'h80000000, 32'h7FFFFFFF);
      drain();

      // zero innovation variance
      set_all(zero_var);
      send(CMD_RESTART, 32'h0, 32'h0);
      send(CMD_STEP, 32'h00010000, 32'h00030000);
      send(CMD_STEP, 32'h0, 32'h0);
      drain();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent % 150 == 0) begin
            drain();
            for (int i = 0; i < 8; i++) rand_cfg[i] = $urandom_range(0, 131072);
            rand_cfg[REG_CONTROL_GAIN] = rand_small();
            rand_cfg[REG_INITIAL_POSITION] = rand_small();
            rand_cfg[REG_INITIAL_VELOCITY] = rand_small();
            if ($urandom_range(0, 3) == 0) rand_cfg[$urandom_range(0, 7)] = $urandom();
            set_all(rand_cfg);
            send(CMD_RESTART, $urandom(), $urandom());
            sent++;
         end
         if (sent > RANDOM_ITEMS - 120) quiet = 1;
         case ($urandom_range(0, 19))
            0: send(CMD_RESTART, $urandom(), $urandom());
            1, 2: send(CMD_STEP, $urandom(), $urandom());
            default: send(CMD_STEP, rand_small(), rand_small());
         endcase
         sent++;
      end
      drain();
      if (mismatches == 0 && expected_estimates.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
